FILE: rtl/checked_signed_integer_alu_assert.svh
// Assertion macros used by the port checker.
// Each macro expects clk and rst in the scope where it is used.
`ifndef CHECKED_SIGNED_INTEGER_ALU_ASSERT_SVH
`define CHECKED_SIGNED_INTEGER_ALU_ASSERT_SVH

// Checked on every edge outside reset.
`define CSIA_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checked on every edge, reset included.
`define CSIA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

FILE: rtl/csia_pkg.sv
`default_nettype none

package csia_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int ACC_WIDTH  = 2 * DATA_WIDTH;

  // Operation codes
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_REM = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;

  typedef struct packed {
    logic [2:0]                   cmd;
    logic signed [DATA_WIDTH-1:0] left_operand;
    logic signed [DATA_WIDTH-1:0] right_operand;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result_value;
    logic [1:0]                   status;
  } rsp_t;

  // One pipeline stage: shared by the shift-add multiplier and the
  // restoring divider. acc holds the partial product or partial remainder,
  // work the multiplier bits or the dividend/quotient bits, opnd the
  // multiplicand or divisor magnitude.
  typedef struct packed {
    logic                  valid;
    logic [2:0]            cmd;
    logic [1:0]            status;
    logic                  neg;
    logic [ACC_WIDTH-1:0]  acc;
    logic [DATA_WIDTH-1:0] work;
    logic [DATA_WIDTH-1:0] opnd;
  } stage_t;

endpackage

`default_nettype wire

FILE: rtl/csia_step.sv
`default_nettype none

module csia_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  csia_pkg::stage_t d,
  output csia_pkg::stage_t q
);
  import csia_pkg::*;

  localparam int W = DATA_WIDTH;

  logic [W:0] trial;
  logic       ge;
  stage_t     nxt;

  // One bit of multiply (MSB first) or one bit of restoring divide
  always_comb begin
    trial = {d.acc[W-1:0], d.work[W-1]};
    ge    = trial >= {1'b0, d.opnd};
    nxt   = d;
    priority if (d.cmd == CMD_MUL) begin
      nxt.acc  = {d.acc[ACC_WIDTH-2:0], 1'b0}
               + {{W{1'b0}}, (d.work[W-1] ? d.opnd : {W{1'b0}})};
      nxt.work = {d.work[W-2:0], 1'b0};
    end else if (d.cmd == CMD_DIV || d.cmd == CMD_REM) begin
      nxt.acc  = {{(W-1){1'b0}}, (ge ? trial - {1'b0, d.opnd} : trial)};
      nxt.work = {d.work[W-2:0], ge};
    end else begin
      nxt = d;
    end
  end

  // Stage register; only valid is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/checked_signed_integer_alu.sv
// Checked signed integer ALU: add, subtract, multiply, divide, remainder
// on two signed operands, with a status of ok, out of range or divide by
// zero; the result is zero whenever the status is not ok.
// Request channel: req_valid / req_stall / req_data. Response channel:
// rsp_valid / rsp_stall / rsp_data. A transfer happens on a clock edge
// with valid high and stall low. Every request gives exactly one response,
// in order.
// Stages: one decode stage, one stage per operand bit in the shared
// multiply/divide pipeline, one output stage. Throughput: one request
// per cycle while req_stall is low; all operations pass through the same
// stages.
// When the receiver stalls, the output register holds its response and
// a one-entry skid register catches the next; req_stall then rises and
// the whole pipeline freezes until the skid register drains.
// Reset (rst, synchronous) drops every request in flight and clears both
// valid outputs.
`default_nettype none

module checked_signed_integer_alu (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  csia_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output csia_pkg::rsp_t rsp_data
);
  import csia_pkg::*;

  localparam int W         = DATA_WIDTH;
  localparam int NUM_STEPS = DATA_WIDTH;

  logic         adv;
  logic [W-1:0] a, b, ma, mb, sum, diff;
  logic         na, nb;
  stage_t       prep_next;
  stage_t       pipe [NUM_STEPS+1];
  stage_t       last;

  logic [ACC_WIDTH-1:0] limit;
  logic                 mul_ovf;
  logic [W-1:0]         mag, val;
  logic [1:0]           st;
  rsp_t                 fin;

  logic skid_valid;
  rsp_t skid_data;

  // Pipeline moves whenever the skid register is empty
  assign adv       = !skid_valid;
  assign req_stall = skid_valid;

  // Decode: magnitudes, add/sub with overflow, special cases
  always_comb begin
    a    = req_data.left_operand;
    b    = req_data.right_operand;
    na   = a[W-1];
    nb   = b[W-1];
    ma   = na ? -a : a;
    mb   = nb ? -b : b;
    sum  = a + b;
    diff = a - b;

    prep_next        = '0;
    prep_next.valid  = req_valid;
    prep_next.cmd    = req_data.cmd;
    prep_next.status = ST_OK;
    unique case (req_data.cmd)
      CMD_ADD: begin
        prep_next.acc = {{W{1'b0}}, sum};
        if (na == nb && sum[W-1] != na) begin
          prep_next.status = ST_RANGE;
        end
      end
      CMD_SUB: begin
        prep_next.acc = {{W{1'b0}}, diff};
        if (na != nb && diff[W-1] != na) begin
          prep_next.status = ST_RANGE;
        end
      end
      CMD_MUL: begin
        prep_next.neg  = (na && b != '0 && !nb) || (a != '0 && !na && nb);
        prep_next.work = mb;
        prep_next.opnd = ma;
      end
      CMD_DIV, CMD_REM: begin
        prep_next.neg  = (req_data.cmd == CMD_DIV) ? (na ^ nb) : na;
        prep_next.work = ma;
        prep_next.opnd = mb;
        priority if (b == '0) begin
          prep_next.status = ST_DIVZERO;
        end else if (a == {1'b1, {(W-1){1'b0}}} && (&b)) begin
          prep_next.status = ST_RANGE;
        end else begin
          prep_next.status = ST_OK;
        end
      end
      default: begin
        prep_next.status = ST_RANGE;
      end
    endcase
  end

  // Decode stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (adv) begin
      pipe[0] <= prep_next;
    end
  end

  // One multiply/divide bit per stage
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    csia_step u_step (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (pipe[i]),
      .q   (pipe[i+1])
    );
  end

  assign last = pipe[NUM_STEPS];

  // Finish: product range check, sign fix-up, zero on error
  always_comb begin
    limit   = last.neg ? {{W{1'b0}}, 1'b1, {(W-1){1'b0}}}
                       : {{(W+1){1'b0}}, {(W-1){1'b1}}};
    mul_ovf = last.acc > limit;
    mag     = (last.cmd == CMD_DIV) ? last.work : last.acc[W-1:0];
    val     = last.neg ? -mag : mag;
    st      = last.status;
    if (st == ST_OK && last.cmd == CMD_MUL && mul_ovf) begin
      st = ST_RANGE;
    end
    fin.status       = st;
    fin.result_value = (st == ST_OK) ? val : '0;
  end

  // Output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        rsp_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= last.valid;
        rsp_data  <= fin;
      end
    end else if (!skid_valid) begin
      skid_valid <= last.valid;
      skid_data  <= fin;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/csia_port_checker.sv
`default_nettype none
`include "checked_signed_integer_alu_assert.svh"

module csia_port_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input csia_pkg::rsp_t rsp_data
);

  // Reset empties the output side
  `CSIA_ASSERT_ALWAYS(a_rst_clears_rsp, $past(rst) |-> !rsp_valid, "rsp_valid after reset")

  // A stalled response stays put
  `CSIA_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "rsp moved while stalled")

  // Backpressure only while a response is waiting
  `CSIA_ASSERT(a_stall_needs_rsp, req_stall |-> rsp_valid, "req_stall without pending rsp")

  // Backpressure starts only after a stalled response
  `CSIA_ASSERT(a_stall_cause, $rose(req_stall) |-> $past(rsp_valid && rsp_stall), "req_stall rose unprompted")

endmodule

bind checked_signed_integer_alu csia_port_checker u_port_checker (.*);

`default_nettype wire

FILE: tb/alu_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the ALU. It works out the expected response of each
// accepted request and compares every accepted response with the oldest one.
module alu_result_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_stall,
  input  csia_pkg::req_t   req_data,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  csia_pkg::rsp_t   rsp_data,
  output int               errors,
  output int               pending,
  output int               checked,
  output int               range_seen,
  output int               divzero_seen
);
  import csia_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int WW = 2 * W + 1;
  localparam logic signed [W-1:0] MOST_NEG  = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MINUS_ONE = '1;

  // expected responses, oldest first
  rsp_t expected_rsp_q[$];

  initial begin
    errors       = 0;
    pending      = 0;
    checked      = 0;
    range_seen   = 0;
    divzero_seen = 0;
  end

  // Exact result on a double-width signed value, then a fit check for the
  // add, subtract and multiply range cases.
  function automatic rsp_t alu_expect(input req_t r);
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic signed [2*W:0] wide;
    logic                arith;
    rsp_t                o;
    a              = r.left_operand;
    b              = r.right_operand;
    wide           = '0;
    arith          = 1'b0;
    o.result_value = '0;
    o.status       = ST_OK;
    case (r.cmd)
      CMD_ADD: begin
        wide  = WW'(a) + WW'(b);
        arith = 1'b1;
      end
      CMD_SUB: begin
        wide  = WW'(a) - WW'(b);
        arith = 1'b1;
      end
      CMD_MUL: begin
        wide  = WW'(a) * WW'(b);
        arith = 1'b1;
      end
      CMD_DIV, CMD_REM: begin
        if (b == '0) begin
          o.status = ST_DIVZERO;
        end else if (a == MOST_NEG && b == MINUS_ONE) begin
          o.status = ST_RANGE;
        end else if (r.cmd == CMD_DIV) begin
          // truncates toward zero
          o.result_value = a / b;
        end else begin
          // sign follows the dividend
          o.result_value = a % b;
        end
      end
      default: o.status = ST_RANGE;
    endcase
    if (arith) begin
      if (wide[2*W:W-1] == {(W+2){wide[W-1]}}) begin
        o.result_value = wide[W-1:0];
      end else begin
        o.status = ST_RANGE;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input rsp_t got, input rsp_t want);
    $display("%0t ns: %s: got value %0d status %0d, expected value %0d status %0d",
             $time, what, got.result_value, got.status, want.result_value, want.status);
    errors++;
  endtask

  // Responses are checked before requests are queued; a response never returns in the cycle its request is taken.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding", rsp_data, '0);
        end else begin
          want = expected_rsp_q.pop_front();
          checked++;
          if (want.status == ST_RANGE) range_seen++;
          if (want.status == ST_DIVZERO) divzero_seen++;
          if (rsp_data.result_value !== want.result_value)
            report_mismatch("result_value mismatch", rsp_data, want);
          if (rsp_data.status !== want.status)
            report_mismatch("status mismatch", rsp_data, want);
        end
      end
      if (req_valid && !req_stall) expected_rsp_q.push_back(alu_expect(req_data));
    end
    pending = expected_rsp_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import csia_pkg::*;

  localparam int W            = DATA_WIDTH;
  localparam int LATENCY      = DATA_WIDTH + 1;
  localparam int RANDOM_ITEMS = 1150;
  localparam int OP_SLOTS     = 6;

  // codes above the last operation; the block reports them as out of range
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  localparam logic signed [W-1:0] MOST_NEG  = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MOST_POS  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINUS_ONE = '1;
  localparam logic signed [W-1:0] HALF_POW  = {{(W-1){1'b0}}, 1'b1} << (W / 2);
  localparam logic signed [W-1:0] HALF_POW1 = {{(W-1){1'b0}}, 1'b1} << (W / 2 - 1);

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  int errors;
  int pending;
  int checked;
  int range_seen;
  int divzero_seen;
  int ops_sent [OP_SLOTS];
  int burst_left;

  checked_signed_integer_alu dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  alu_result_checker u_alu_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_data     (req_data),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp_data     (rsp_data),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .range_seen   (range_seen),
    .divzero_seen (divzero_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit, far above the slowest correct run
  initial begin
    #20_000_000;
    $display("** checked_signed_integer_alu: FAILED **");
    $finish;
  end

  // Receiver stall: spans of free flow, light, heavy and periodic stalling.
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          0:       rsp_stall = 1'b0;
          1:       rsp_stall = ($urandom_range(0, 3) == 0);
          2:       rsp_stall = ($urandom_range(0, 3) != 0);
          default: rsp_stall = ((i % 13) < 7);
        endcase
      end
    end
  end

  // One request; afterwards the sender may close its burst and idle.
  task automatic send_req(input logic [2:0] cmd, input logic signed [W-1:0] a,
                          input logic signed [W-1:0] b);
    req_t r;
    r.cmd           = cmd;
    r.left_operand  = a;
    r.right_operand = b;
    req_data        = r;
    req_valid       = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    ops_sent[(cmd > CMD_REM) ? OP_SLOTS - 1 : cmd]++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 8);
    end
  endtask

  // hold off until every outstanding response has come back
  task automatic drain_wait();
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Operand mix: full random, small, extremes, powers of two, half width, arithmetic right shifts.
  function automatic logic signed [W-1:0] pick_operand();
    logic [63:0]           raw;
    logic signed [W/2-1:0] half;
    logic signed [W-1:0]   v;
    int                    k;
    raw = {$urandom(), $urandom()};
    v   = raw[W-1:0];
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3: v = $signed($urandom_range(0, 40)) - 20;
      4: begin
        case ($urandom_range(0, 6))
          0:       v = MOST_NEG;
          1:       v = MOST_POS;
          2:       v = '0;
          3:       v = MINUS_ONE;
          4:       v = 1;
          5:       v = MOST_NEG + 1;
          default: v = MOST_POS - 1;
        endcase
      end
      5: begin
        k    = $urandom_range(0, W - 1);
        v    = '0;
        v[k] = 1'b1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      6, 7: begin
        half = raw[W/2-1:0];
        v    = W'(half);
      end
      default: v = v >>> $urandom_range(1, W - 1);
    endcase
    return v;
  endfunction

  initial begin
    logic [2:0]          cmd;
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    for (int i = 0; i < OP_SLOTS; i++) ops_sent[i] = 0;
    burst_left = 6;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // add and subtract edges
    send_req(CMD_ADD, MOST_POS, 1);
    send_req(CMD_ADD, MOST_NEG, MINUS_ONE);
    send_req(CMD_ADD, MOST_POS, MOST_NEG);
    send_req(CMD_SUB, MOST_NEG, 1);
    send_req(CMD_SUB, MOST_POS, MINUS_ONE);
    send_req(CMD_SUB, '0, MOST_NEG);
    send_req(CMD_SUB, MINUS_ONE, MOST_NEG);
    // multiply: most negative product allowed, its negation is not
    send_req(CMD_MUL, MOST_NEG, 1);
    send_req(CMD_MUL, MOST_NEG, MINUS_ONE);
    send_req(CMD_MUL, HALF_POW, HALF_POW1);
    send_req(CMD_MUL, -HALF_POW, HALF_POW1);
    send_req(CMD_MUL, MOST_POS, MOST_POS);
    send_req(CMD_MUL, '0, MOST_NEG);
    // divide and remainder signs, zero divisor, most negative by minus one
    send_req(CMD_DIV, 7, -2);
    send_req(CMD_DIV, -7, 2);
    send_req(CMD_REM, 7, -2);
    send_req(CMD_REM, -7, 2);
    send_req(CMD_DIV, MOST_POS, '0);
    send_req(CMD_REM, MOST_NEG, '0);
    send_req(CMD_DIV, MOST_NEG, MINUS_ONE);
    send_req(CMD_REM, MOST_NEG, MINUS_ONE);
    send_req(CMD_DIV, MOST_NEG, 1);
    send_req(CMD_REM, MOST_NEG, MOST_POS);
    // unused operation codes
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) send_req(3'(c), 5, 3);
    drain_wait();

    // random requests, with two full drains along the way
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 19) != 0) cmd = 3'($urandom_range(CMD_ADD, CMD_REM));
      else cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      a = pick_operand();
      b = pick_operand();
      if (cmd == CMD_DIV || cmd == CMD_REM) begin
        case ($urandom_range(0, 39))
          0, 1: b = '0;
          2: begin
            a = MOST_NEG;
            b = MINUS_ONE;
          end
          default: ;
        endcase
      end
      send_req(cmd, a, b);
      if (n == 400 || n == 800) drain_wait();
    end

    drain_wait();
    repeat (2 * LATENCY) @(negedge clk);

    $display("Covered %0d requests: add %0d, sub %0d, mul %0d, div %0d, rem %0d, unused %0d",
             ops_sent.sum(), ops_sent[CMD_ADD], ops_sent[CMD_SUB], ops_sent[CMD_MUL],
             ops_sent[CMD_DIV], ops_sent[CMD_REM], ops_sent[OP_SLOTS - 1]);
    $display("Checked %0d responses: %0d out of range, %0d divide by zero, %0d mismatches",
             checked, range_seen, divzero_seen, errors);
    if (errors == 0) begin
      $display("** checked_signed_integer_alu: PASSED **");
    end else begin
      $display("** checked_signed_integer_alu: FAILED **");
    end
    $finish;
  end

endmodule
